// ===== hw/rtl/looping_keyframe_position_sampler_top_defines.svh =====
// Assertion macros for the checker file.
`ifndef LOOPING_KEYFRAME_POSITION_SAMPLER_TOP_DEFINES_SVH
`define LOOPING_KEYFRAME_POSITION_SAMPLER_TOP_DEFINES_SVH
// same-cycle implication
`define LKPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define LKPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

// ===== hw/rtl/lkps_pkg.sv =====
// Shared constants and types for the keyframe position sampler.
package lkps_pkg;
  localparam int KEY_DEPTH = 64;
  localparam int KEY_AW = $clog2(KEY_DEPTH);
  localparam int CNT_W = KEY_AW + 1;
  localparam int DVD_W = 48;
  localparam int DVS_W = 32;
  localparam logic [15:0] DEFAULT_TPS = 16'd25;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef enum logic [1:0] {
    CMD_WRITE_KEY = 2'd0,
    CMD_SAMPLE    = 2'd1,
    CMD_PLAY      = 2'd2,
    CMD_PAUSE     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    CFG_LOOP_ENABLE = 3'd0,
    CFG_RANGE_START = 3'd1,
    CFG_RANGE_END   = 3'd2,
    CFG_TPS         = 3'd3,
    CFG_KEY_COUNT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;
endpackage

// ===== hw/rtl/lkps_ram.sv =====
// Generic single-port-write, registered-read RAM.
module lkps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/lkps_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module lkps_div import lkps_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          state;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [5:0]       cnt;
  logic             done;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (req.start) begin
            dvd   <= req.dividend;
            dvs   <= req.divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[DVS_W]) begin
            rem <= diff[DVS_W-1:0];
          end else begin
            rem <= trial[DVS_W-1:0];
          end
          dvd <= {dvd[DVD_W-2:0], ~diff[DVS_W]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'(DVD_W - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = dvd;
  assign rsp.rem  = rem;
endmodule

// ===== hw/rtl/looping_keyframe_position_sampler_top.sv =====
// Sample: a modulo of the tick count, a scan over the keys, a divide for the factor and a
//   per-axis lerp; both divides run on the one shared divider.
// Write-key, play, pause and non-playing samples go straight to the result register.
// One transaction at a time; the result register frees the input side.
// Synchronous active-high reset clears control state, flags and config;
//   the key tables are undefined until written.
module looping_keyframe_position_sampler_top import lkps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic [5:0]         key_index,
  input  logic [31:0]        key_time,
  input  logic signed [31:0] value_x,
  input  logic signed [31:0] value_y,
  input  logic signed [31:0] value_z,
  input  logic [31:0]        elapsed_seconds,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               pose_valid,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [31:0]        anim_time,
  output logic               playing
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CHECK, S_MOD, S_POST, S_SINGLE, S_SCAN, S_SCAN_CMP,
    S_F0, S_F1, S_F2, S_FDIV, S_LMUL, S_LACC, S_OUT
  } state_t;

  state_t      state;
  logic        loop_enable;
  logic [31:0] range_start;
  logic [31:0] range_end;
  logic [15:0] tps;
  logic [6:0]  key_count;

  logic        play_flag;
  logic [31:0] last_anim;
  logic [31:0] es;
  logic [47:0] ticks;
  logic        res_valid;
  logic [31:0] res_pos [3];
  logic [KEY_AW-1:0] scan_i;
  logic [KEY_AW-1:0] seg;
  logic [31:0] t0;
  logic [95:0] p0;
  logic [95:0] p1;
  logic [16:0] factor;
  logic [1:0]  axis;
  logic signed [50:0] prod;

  logic        accept;
  logic        out_free;
  logic [15:0] tps_eff;
  logic [31:0] len;
  logic [CNT_W-1:0] n;
  logic [KEY_AW-1:0] raddr;
  logic [31:0] rd_time;
  logic [95:0] rd_pos;
  logic [32:0] span;
  logic [32:0] num;
  logic [31:0] a_sel;
  logic [31:0] b_sel;
  logic signed [32:0] d;
  div_req_t    dreq;
  div_rsp_t    drsp;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign tps_eff  = (tps == '0) ? DEFAULT_TPS : tps;
  assign len      = (range_end > range_start) ? (range_end - range_start) : '0;
  assign n        = (key_count > CNT_W'(KEY_DEPTH)) ? CNT_W'(KEY_DEPTH) : key_count;
  assign span     = {1'b0, rd_time} - {1'b0, t0};
  assign num      = {1'b0, last_anim} - {1'b0, t0};

  always_comb begin
    case (state)
      S_SCAN:  raddr = scan_i + KEY_AW'(1);
      S_F0:    raddr = seg;
      S_F1:    raddr = seg + KEY_AW'(1);
      default: raddr = '0;
    endcase
  end

  always_comb begin
    case (axis)
      2'd0:    begin a_sel = p0[95:64]; b_sel = p1[95:64]; end
      2'd1:    begin a_sel = p0[63:32]; b_sel = p1[63:32]; end
      default: begin a_sel = p0[31:0];  b_sel = p1[31:0];  end
    endcase
  end
  assign d = $signed({b_sel[31], b_sel}) - $signed({a_sel[31], a_sel});

  always_comb begin
    dreq = '0;
    if (state == S_CHECK) begin
      dreq.start    = (loop_enable || ticks < {16'd0, len}) && len != '0;
      dreq.dividend = ticks;
      dreq.divisor  = len;
    end else if (state == S_F2) begin
      dreq.start    = !(span[32] || span == '0 || num[32] || num == '0) && num < span;
      dreq.dividend = {num[31:0], 16'd0};
      dreq.divisor  = span[31:0];
    end
  end

  lkps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  lkps_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_times (
    .clk(clk), .we(accept && command == CMD_WRITE_KEY), .waddr(key_index),
    .wdata(key_time), .raddr(raddr), .rdata(rd_time)
  );

  lkps_ram #(.WIDTH(96), .DEPTH(KEY_DEPTH)) u_pos (
    .clk(clk), .we(accept && command == CMD_WRITE_KEY), .waddr(key_index),
    .wdata({value_x, value_y, value_z}), .raddr(raddr), .rdata(rd_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b1;
      range_start <= '0;
      range_end   <= '0;
      tps         <= DEFAULT_TPS;
      key_count   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LOOP_ENABLE: loop_enable <= cfg_data[0];
        CFG_RANGE_START: range_start <= cfg_data;
        CFG_RANGE_END:   range_end   <= cfg_data;
        CFG_TPS:         tps         <= cfg_data[15:0];
        CFG_KEY_COUNT:   key_count   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      play_flag <= 1'b0;
      last_anim <= '0;
      out_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_valid  <= 1'b0;
            res_pos[0] <= '0;
            res_pos[1] <= '0;
            res_pos[2] <= '0;
            es         <= elapsed_seconds;
            state      <= S_OUT;
            case (command)
              CMD_PLAY:   play_flag <= 1'b1;
              CMD_PAUSE:  play_flag <= 1'b0;
              CMD_SAMPLE: if (play_flag) state <= S_MUL;
              default: ;
            endcase
          end
        end
        S_MUL: begin
          ticks <= es * tps_eff;
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (!loop_enable && ticks >= {16'd0, len}) begin
            play_flag <= 1'b0;
            state     <= S_OUT;
          end else if (len == '0) begin
            last_anim <= range_start;
            state     <= S_POST;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (drsp.done) begin
            last_anim <= drsp.rem + range_start;
            state     <= S_POST;
          end
        end
        S_POST: begin
          scan_i <= '0;
          seg    <= '0;
          if (n == '0) begin
            state <= S_OUT;
          end else if (n == CNT_W'(1)) begin
            state <= S_SINGLE;
          end else if (last_anim == '0) begin
            state <= S_F0;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SINGLE: state <= S_F1;
        S_SCAN:   state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (last_anim < rd_time) begin
            seg   <= scan_i;
            state <= S_F0;
          end else if (CNT_W'(scan_i) + CNT_W'(2) >= n) begin
            seg   <= '0;
            state <= S_F0;
          end else begin
            scan_i <= scan_i + KEY_AW'(1);
            state  <= S_SCAN;
          end
        end
        S_F0: state <= S_F1;
        S_F1: begin
          t0 <= rd_time;
          p0 <= rd_pos;
          if (n == CNT_W'(1)) begin
            res_valid  <= 1'b1;
            res_pos[0] <= rd_pos[95:64];
            res_pos[1] <= rd_pos[63:32];
            res_pos[2] <= rd_pos[31:0];
            state      <= S_OUT;
          end else begin
            state <= S_F2;
          end
        end
        S_F2: begin
          p1   <= rd_pos;
          axis <= 2'd0;
          if (span[32] || span == '0 || num[32] || num == '0) begin
            factor <= '0;
            state  <= S_LMUL;
          end else if (num >= span) begin
            factor <= ONE_Q16;
            state  <= S_LMUL;
          end else begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (drsp.done) begin
            factor <= drsp.quot[16:0];
            state  <= S_LMUL;
          end
        end
        S_LMUL: begin
          prod  <= $signed({1'b0, factor}) * d;
          state <= S_LACC;
        end
        S_LACC: begin
          res_pos[axis] <= a_sel + prod[47:16];
          if (axis == 2'd2) begin
            res_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= S_LMUL;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            pose_valid <= res_valid;
            pos_x      <= res_pos[0];
            pos_y      <= res_pos[1];
            pos_z      <= res_pos[2];
            anim_time  <= last_anim;
            playing    <= play_flag;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/lkps_checker.sv =====
// Port-level checker for the keyframe position sampler, with its bind.
`include "looping_keyframe_position_sampler_top_defines.svh"
module lkps_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        pose_valid,
  input logic [31:0] pos_x,
  input logic [31:0] pos_y,
  input logic [31:0] pos_z,
  input logic        playing
);
  `LKPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `LKPS_ASSERT_IMPL(a_zero_pose, out_valid && !pose_valid, (pos_x | pos_y | pos_z) == '0)
  `LKPS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `LKPS_ASSERT_IMPL(a_pose_while_playing, out_valid && pose_valid, playing)
endmodule

bind looping_keyframe_position_sampler_top lkps_checker u_lkps_checker (.*);

// ===== dv/tb_looping_keyframe_position_sampler_top.sv =====
// Self-checking testbench for the looping keyframe position sampler.
class pose_scoreboard;
  bit [31:0] kt[64];
  logic signed [31:0] kp[64][3];
  bit loop_en = 1;
  bit [31:0] r_start, r_end;
  bit [15:0] tps = 16'd25;
  bit [6:0] kcount;
  bit play_flag;
  bit [31:0] last_t;
  bit [129:0] pending[$];
  int errors;

  function automatic logic signed [31:0] lerp(logic signed [31:0] a, logic signed [31:0] b,
                                               longint f);
    longint d, p, q;
    d = longint'(b) - longint'(a);
    p = f * d;
    if (p >= 0) q = p / 65536;
    else q = -((-p + 65535) / 65536);
    return 32'(longint'(a) + q);
  endfunction

  function void set_reg(int idx, bit [31:0] v);
    case (idx)
      0: loop_en = v[0];
      1: r_start = v;
      2: r_end = v;
      3: tps = v[15:0];
      4: kcount = v[6:0];
      default: ;
    endcase
  endfunction

  function void note_input(bit [1:0] c, bit [5:0] ki, bit [31:0] kt_in,
                           bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] es);
    bit pv;
    logic signed [31:0] p[3];
    longint unsigned ticks, len, tp;
    int n, seg;
    longint span, num, f;
    pv = 0; p[0] = 0; p[1] = 0; p[2] = 0;
    case (c)
      lkps_pkg::CMD_WRITE_KEY: begin
        kt[ki] = kt_in; kp[ki][0] = x; kp[ki][1] = y; kp[ki][2] = z;
      end
      lkps_pkg::CMD_PLAY: play_flag = 1;
      lkps_pkg::CMD_PAUSE: play_flag = 0;
      default: if (play_flag) begin
        tp = (tps == 0) ? 25 : tps;
        ticks = longint'(es) * tp;
        len = (r_end > r_start) ? r_end - r_start : 0;
        n = (kcount > 64) ? 64 : kcount;
        if (!loop_en && ticks >= len) play_flag = 0;
        else begin
          last_t = 32'((len != 0 ? ticks % len : 0) + r_start);
          if (n == 1) begin
            p = kp[0]; pv = 1;
          end else if (n > 1) begin
            seg = 0;
            for (int i = 0; i + 1 < n; i++)
              if (last_t > 0 && last_t < kt[i+1]) begin seg = i; break; end
            span = longint'(kt[seg+1]) - longint'(kt[seg]);
            num = longint'(last_t) - longint'(kt[seg]);
            if (span <= 0 || num <= 0) f = 0;
            else if (num >= span) f = 65536;
            else f = (num * 65536) / span;
            for (int k = 0; k < 3; k++) p[k] = lerp(kp[seg][k], kp[seg+1][k], f);
            pv = 1;
          end
        end
      end
    endcase
    pending.push_back({pv, p[0], p[1], p[2], last_t, play_flag});
  endfunction

  function void check_result(bit [129:0] got);
    bit [129:0] e;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    e = pending.pop_front();
    if (e !== got) begin
      errors++;
      if (errors <= 10) $display("mismatch: exp %h got %h", e, got);
    end
  endfunction
endclass

module tb_looping_keyframe_position_sampler_top;
  import lkps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] command = 0;
  logic [5:0] key_index = 0;
  logic [31:0] key_time = 0, elapsed_seconds = 0;
  logic signed [31:0] value_x = 0, value_y = 0, value_z = 0;
  logic cfg_write = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic pose_valid, playing;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [31:0] anim_time;

  pose_scoreboard sb = new();
  bit hold_rx = 0;
  int cycles = 0;
  bit [63:0] written;

  always #6 clk = ~clk;

  looping_keyframe_position_sampler_top dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_looping_keyframe_position_sampler_top: errors");
      $finish;
    end
    if (!rst && out_valid && !out_stall)
      sb.check_result({pose_valid, pos_x, pos_y, pos_z, anim_time, playing});
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (hold_rx) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 9) < 3) && ($urandom_range(0, 3) != 0);
  end

  task automatic send(bit [1:0] c, bit [5:0] ki, bit [31:0] t,
                      bit [31:0] x, bit [31:0] y, bit [31:0] z, bit [31:0] es);
    command <= c; key_index <= ki; key_time <= t;
    value_x <= x; value_y <= y; value_z <= z; elapsed_seconds <= es;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(c, ki, t, x, y, z, es);
    if (c == CMD_WRITE_KEY) written[ki] = 1;
    @(negedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic cfg(cfg_idx_t idx, bit [31:0] v);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_write <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic write_keys(int n, bit sorted);
    bit [31:0] t;
    t = $urandom_range(0, 3) << 16;
    for (int i = 0; i < n; i++) begin
      send(CMD_WRITE_KEY, 6'(i), sorted ? t : $urandom(), $urandom(), $urandom(), $urandom(),
           0);
      t = t + $urandom_range(1, 40) * 32'h8000;
    end
  endtask

  task automatic sample_rand();
    bit [31:0] es;
    case ($urandom_range(0, 3))
      0: es = $urandom();
      1: es = $urandom_range(0, 32'h0004_0000);
      2: es = 0;
      default: es = $urandom_range(0, 32'h0000_ffff);
    endcase
    send(CMD_SAMPLE, 6'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(), es);
  endtask

  initial begin
    int n, b;
    written = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed
    cfg(CFG_KEY_COUNT, 0);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h10000);
    send(CMD_PLAY, 0, 0, 0, 0, 0, 0);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h10000);
    write_keys(4, 1);
    send(CMD_WRITE_KEY, 4, 32'hffffffff, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0);
    drain();
    cfg(CFG_KEY_COUNT, 1);
    cfg(CFG_RANGE_END, 32'h0020_0000);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'hffffffff);
    drain();
    cfg(CFG_KEY_COUNT, 5);
    cfg(CFG_TPS, 0);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h0000_8000);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 0);
    send(CMD_PAUSE, 0, 0, 0, 0, 0, 0);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h10000);
    send(CMD_PLAY, 0, 0, 0, 0, 0, 0);
    drain();
    cfg(CFG_LOOP_ENABLE, 0);
    cfg(CFG_TPS, 16'hffff);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h10);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'hffffffff);
    drain();
    cfg(CFG_RANGE_START, 32'hffffffff);
    cfg(CFG_LOOP_ENABLE, 1);
    send(CMD_PLAY, 0, 0, 0, 0, 0, 0);
    send(CMD_SAMPLE, 0, 0, 0, 0, 0, 32'h1234);
    drain();
    // random phases
    for (int ph = 0; ph < 14; ph++) begin
      n = (ph % 5 == 0) ? 64 : $urandom_range(2, 12);
      cfg(CFG_KEY_COUNT, 0);
      write_keys(n, $urandom_range(0, 4) != 0);
      drain();
      cfg(CFG_KEY_COUNT, (ph == 3) ? 127 - 63 * (written != '1) : $urandom_range(1, n));
      if (ph == 3 && written != '1) cfg(CFG_KEY_COUNT, n);
      cfg(CFG_LOOP_ENABLE, $urandom_range(0, 3) != 0);
      cfg(CFG_RANGE_START, (ph == 1) ? 0 : $urandom_range(0, 32'h0004_0000));
      cfg(CFG_RANGE_END, (ph == 2) ? 0 : (ph == 4) ? 32'hffffffff
                                        : $urandom_range(0, 32'h0030_0000));
      cfg(CFG_TPS, (ph == 5) ? 1 : (ph == 6) ? 16'hffff : $urandom_range(0, 60));
      if (ph == 7) begin
        fork
          begin hold_rx = 1; repeat (400) @(negedge clk); hold_rx = 0; end
          for (int i = 0; i < 20; i++) sample_rand();
        join
        drain();
      end
      b = 0;
      while (b < 105) begin
        for (int k = $urandom_range(1, 12); k > 0 && b < 105; k--) begin
          if ($urandom_range(0, 15) == 0) send(CMD_PAUSE, 0, 0, 0, 0, 0, 0);
          else if ($urandom_range(0, 5) == 0) send(CMD_PLAY, 0, 0, 0, 0, 0, 0);
          else if ($urandom_range(0, 30) == 0)
            send(CMD_WRITE_KEY, 6'($urandom_range(0, n - 1)), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom());
          else sample_rand();
          b++;
        end
        if ($urandom_range(0, 2) != 0) idle_gap();
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_looping_keyframe_position_sampler_top: clean");
    else
      $display("tb_looping_keyframe_position_sampler_top: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lkps_pkg.sv
hw/rtl/lkps_ram.sv
hw/rtl/lkps_div.sv
hw/rtl/looping_keyframe_position_sampler_top.sv
hw/rtl/lkps_checker.sv
dv/tb_looping_keyframe_position_sampler_top.sv
